[rtl/sector_cache_tag_controller_unit_defines.svh]
// -----------------------------------------------------------------------------
// sector cache tag controller assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// -----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`define SECTOR_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define SCTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sctc_pkg.sv]
// -----------------------------------------------------------------------------
// sctc_pkg
// shared types and field widths of the sector cache tag controller
// -----------------------------------------------------------------------------
package sctc_pkg;

   localparam int OP_W       = 2;
   localparam int SECTOR_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int SLOT_OUT_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INIT  = 2'd2
   } op_type;

   // tag store update commands issued by the policy logic
   typedef struct packed {
      logic fill_en;
      logic inval_en;
      logic init_en;
   } ctl_type;

endpackage

[rtl/sctc_tag_array.sv]
// -----------------------------------------------------------------------------
// sctc_tag_array
// per-drive valid bits and sector tags with parallel hit and range compare
// -----------------------------------------------------------------------------
module sctc_tag_array
   import sctc_pkg::*;
#(
   parameter int DRIVES = 2,
   parameter int SLOTS  = 64,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int DIDX_W = (DRIVES > 1) ? $clog2(DRIVES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                drive,
   input  logic [SECTOR_W-1:0] sector,
   input  logic [COUNT_W-1:0]  count,
   input  ctl_type             ctl,
   input  logic [SLOT_W-1:0]   fill_slot,
   output logic                hit,
   output logic [SLOT_W-1:0]   hit_slot
);

   logic                valid_ff [DRIVES][SLOTS];
   logic [SECTOR_W-1:0] tag_ff   [DRIVES][SLOTS];

   logic              drive_ok;
   logic [DIDX_W-1:0] drv_idx;
   logic [SECTOR_W:0] range_lo;
   logic [SECTOR_W:0] range_hi;
   logic [SLOTS-1:0]  match;
   logic [SLOTS-1:0]  in_range;

   assign drive_ok = (int'(drive) < DRIVES);
   assign drv_idx  = drive_ok ? DIDX_W'(drive) : '0;
   assign range_lo = {1'b0, sector};
   assign range_hi = range_lo + (SECTOR_W+1)'(count);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i]    = valid_ff[drv_idx][i] && (tag_ff[drv_idx][i] == sector);
         in_range[i] = valid_ff[drv_idx][i] && ({1'b0, tag_ff[drv_idx][i]} >= range_lo)
                       && ({1'b0, tag_ff[drv_idx][i]} < range_hi);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DRIVES; d++) begin
            for (int i = 0; i < SLOTS; i++) begin
               valid_ff[d][i] <= 1'b0;
            end
         end
      end else begin
         for (int d = 0; d < DRIVES; d++) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (DIDX_W'(d) == drv_idx) begin
                  if (ctl.init_en) begin
                     valid_ff[d][i] <= 1'b0;
                  end else if (ctl.inval_en && in_range[i]) begin
                     valid_ff[d][i] <= 1'b0;
                  end else if (ctl.fill_en && (fill_slot == SLOT_W'(i))) begin
                     valid_ff[d][i] <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fill_en) begin
         tag_ff[drv_idx][fill_slot] <= sector;
      end
   end

endmodule

[rtl/sctc_policy.sv]
// -----------------------------------------------------------------------------
// sctc_policy
// fifo fill pointers, request decode and the result register
// -----------------------------------------------------------------------------
module sctc_policy
   import sctc_pkg::*;
#(
   parameter int DRIVES = 2,
   parameter int SLOTS  = 64,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int DIDX_W = (DRIVES > 1) ? $clog2(DRIVES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [OP_W-1:0]       op,
   input  logic                  drive,
   input  logic [COUNT_W-1:0]    count,
   input  logic                  backing_ok,
   input  logic                  hit,
   input  logic [SLOT_W-1:0]     hit_slot,
   output ctl_type               ctl,
   output logic [SLOT_W-1:0]     fill_slot,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_slot_used,
   output logic                  rsp_status
);

   logic [SLOT_W-1:0] fill_ptr_ff [DRIVES];

   logic                  strobe_ff;
   logic                  hit_ff,    hit_in;
   logic [SLOT_OUT_W-1:0] slot_ff,   slot_in;
   logic                  used_ff,   used_in;
   logic                  status_ff, status_in;

   logic              drive_ok;
   logic [DIDX_W-1:0] drv_idx;
   logic [SLOT_W-1:0] ptr_cur;
   logic [SLOT_W-1:0] ptr_next;
   logic              single;

   assign drive_ok = (int'(drive) < DRIVES);
   assign drv_idx  = drive_ok ? DIDX_W'(drive) : '0;
   assign ptr_cur  = fill_ptr_ff[drv_idx];
   assign ptr_next = (ptr_cur == SLOT_W'(SLOTS - 1)) ? '0 : ptr_cur + 1'b1;
   assign single   = (count == COUNT_W'(1));
   assign fill_slot = ptr_cur;

   always_comb begin
      ctl       = '0;
      hit_in    = 1'b0;
      slot_in   = '0;
      used_in   = 1'b0;
      status_in = 1'b0;
      if (item_valid) begin
         if (!drive_ok) begin
            status_in = 1'b1;
         end else begin
            unique case (op)
               OP_READ: begin
                  if (single && hit) begin
                     hit_in  = 1'b1;
                     slot_in = SLOT_OUT_W'(hit_slot);
                     used_in = 1'b1;
                  end else if (!backing_ok) begin
                     status_in = 1'b1;
                  end else if (single) begin
                     ctl.fill_en = 1'b1;
                     slot_in     = SLOT_OUT_W'(ptr_cur);
                     used_in     = 1'b1;
                  end
               end
               OP_WRITE: begin
                  ctl.inval_en = 1'b1;
                  status_in    = !backing_ok;
               end
               OP_INIT: begin
                  ctl.init_en = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         for (int d = 0; d < DRIVES; d++) begin
            fill_ptr_ff[d] <= '0;
         end
      end else begin
         strobe_ff <= item_valid;
         if (ctl.fill_en) begin
            fill_ptr_ff[drv_idx] <= ptr_next;
         end else if (ctl.init_en) begin
            fill_ptr_ff[drv_idx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      used_ff   <= used_in;
      status_ff <= status_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_slot_used = used_ff;
   assign rsp_status    = status_ff;

endmodule

[rtl/sector_cache_tag_controller_unit.sv]
// -----------------------------------------------------------------------------
// sector_cache_tag_controller_unit
// fully associative fifo tag and policy engine of a per-drive sector cache
// -----------------------------------------------------------------------------
// an item is taken on every cycle that start is high; busy is always low.
// each item gives exactly one result, via the request register and the
// result register, shown for one cycle with rsp_strobe high. the receiver
// cannot stall, so results must be taken as they come. the figure of one
// item per cycle is set by the single-pass compare of the item against
// all tags of its drive, which sits between the request register and the
// result register; tag and pointer updates land at the same edge, so the
// following item always sees them. no clearing pass is needed after reset.
// -----------------------------------------------------------------------------
`include "sector_cache_tag_controller_unit_defines.svh"

module sector_cache_tag_controller_unit
   import sctc_pkg::*;
#(
   parameter int DRIVES = 2,
   parameter int SLOTS  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic                  req_drive,
   input  logic [SECTOR_W-1:0]   req_sector,
   input  logic [COUNT_W-1:0]    req_count,
   input  logic                  req_backing_ok,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_slot_used,
   output logic                  rsp_status
);

   localparam int SLOT_W = $clog2(SLOTS);

   // request register
   logic                req_v_ff;
   logic [OP_W-1:0]     req_op_ff;
   logic                req_drive_ff;
   logic [SECTOR_W-1:0] req_sector_ff;
   logic [COUNT_W-1:0]  req_count_ff;
   logic                req_ok_ff;

   // between policy and tag store
   ctl_type           ctl;
   logic [SLOT_W-1:0] fill_slot;
   logic              hit;
   logic [SLOT_W-1:0] hit_slot;

   // fully pipelined, never holds off the sender
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else begin
         req_v_ff <= start && !busy;
      end
   end

   // payload needs no reset, it is qualified by req_v_ff
   always_ff @(posedge clock) begin
      req_op_ff     <= req_op;
      req_drive_ff  <= req_drive;
      req_sector_ff <= req_sector;
      req_count_ff  <= req_count;
      req_ok_ff     <= req_backing_ok;
   end

   // valid bits and tags, parallel hit lookup and write-range invalidate
   sctc_tag_array #(
      .DRIVES (DRIVES),
      .SLOTS  (SLOTS)
   ) u_tag_array (
      .clock     (clock),
      .reset     (reset),
      .drive     (req_drive_ff),
      .sector    (req_sector_ff),
      .count     (req_count_ff),
      .ctl       (ctl),
      .fill_slot (fill_slot),
      .hit       (hit),
      .hit_slot  (hit_slot)
   );

   // op decode, fifo pointers and result register
   sctc_policy #(
      .DRIVES (DRIVES),
      .SLOTS  (SLOTS)
   ) u_policy (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_v_ff),
      .op            (req_op_ff),
      .drive         (req_drive_ff),
      .count         (req_count_ff),
      .backing_ok    (req_ok_ff),
      .hit           (hit),
      .hit_slot      (hit_slot),
      .ctl           (ctl),
      .fill_slot     (fill_slot),
      .rsp_strobe    (rsp_strobe),
      .rsp_hit       (rsp_hit),
      .rsp_slot      (rsp_slot),
      .rsp_slot_used (rsp_slot_used),
      .rsp_status    (rsp_status)
   );

   // a hit always reports a used slot and good status
   `SCTC_ASSERT_NOW(a_hit_coherent, rsp_strobe && rsp_hit, rsp_slot_used && !rsp_status, "hit without used slot or with error")
   // only reads touch slots
   `SCTC_ASSERT_NEXT(a_nonread_no_slot, req_v_ff && (req_op_ff != OP_READ), !rsp_slot_used && !rsp_hit, "non-read item reported a slot")
   // multi-sector or empty reads never hit
   `SCTC_ASSERT_NEXT(a_multi_no_hit, req_v_ff && (req_count_ff != COUNT_W'(1)), !rsp_hit, "hit on a read of other than one sector")

endmodule

[tb/sv/tb_top.sv]
// -----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sector cache tag controller: a table of
// directed requests, then about two thousand random ones, each checked
// against a behavioral model of the per-drive fifo tag store
// -----------------------------------------------------------------------------
module tb_top
   import sctc_pkg::*;
();

   localparam int DRIVE_COUNT = 2;
   localparam int SLOT_COUNT  = 64;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PRINT_CAP    = 40;

   // op code 3 has no meaning; the block must answer with an all-zero result
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic ST_OK          = 1'b0;
   localparam logic ST_BACKING_ERR = 1'b1;

   // directed rows either carry a hand-written answer or defer to the model
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  used;
      logic                  status;
   } cache_result_type;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic                drv;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
      logic                ok;
      bit                  pinned;
      cache_result_type    want;
   } cache_req_type;

   // every input starts known; reset is high from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = OP_READ;
   logic                  req_drive = 1'b0;
   logic [SECTOR_W-1:0]   req_sector = '0;
   logic [COUNT_W-1:0]    req_count = '0;
   logic                  req_backing_ok = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_slot_used;
   logic                  rsp_status;

   // hand-written answer that travels with the item on the input side
   bit               typed_en = 1'b0;
   cache_result_type typed_result = '0;

   // model copy of the tag store
   bit                  tag_valid  [DRIVE_COUNT][SLOT_COUNT];
   logic [SECTOR_W-1:0] tag_sector [DRIVE_COUNT][SLOT_COUNT];
   int                  fill_ptr   [DRIVE_COUNT];

   cache_result_type outstanding[$];
   cache_req_type    plan[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;

   sector_cache_tag_controller_unit #(
      .DRIVES (DRIVE_COUNT),
      .SLOTS  (SLOT_COUNT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_drive      (req_drive),
      .req_sector     (req_sector),
      .req_count      (req_count),
      .req_backing_ok (req_backing_ok),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_slot       (rsp_slot),
      .rsp_slot_used  (rsp_slot_used),
      .rsp_status     (rsp_status)
   );

   always #10 clock = ~clock;

   // one line per mismatch, capped so a broken block cannot flood the log
   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   function automatic void clear_tags();
      for (int d = 0; d < DRIVE_COUNT; d++) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            tag_valid[d][s]  = 1'b0;
            tag_sector[d][s] = '0;
         end
         fill_ptr[d] = 0;
      end
   endfunction

   // behavior of one request against the tag store, updating the store as
   // the block would
   function automatic cache_result_type access_tags(input logic [OP_W-1:0] op,
                                                    input logic drv,
                                                    input logic [SECTOR_W-1:0] sector,
                                                    input logic [COUNT_W-1:0] count,
                                                    input logic ok);
      cache_result_type r;
      logic [SECTOR_W:0] lo;
      logic [SECTOR_W:0] hi;
      int p;
      r = '0;
      case (op)
         OP_READ: begin
            // only a single-sector read is looked up
            if (count == 1) begin
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  if (tag_valid[drv][s] && tag_sector[drv][s] == sector) begin
                     r.hit  = 1'b1;
                     r.slot = s[SLOT_OUT_W-1:0];
                     r.used = 1'b1;
                     return r;
                  end
               end
            end
            if (!ok) begin
               r.status = ST_BACKING_ERR;
               return r;
            end
            // successful single-sector miss fills at the fifo pointer
            if (count == 1) begin
               p = fill_ptr[drv];
               tag_valid[drv][p]  = 1'b1;
               tag_sector[drv][p] = sector;
               fill_ptr[drv] = (p == SLOT_COUNT - 1) ? 0 : p + 1;
               r.slot = p[SLOT_OUT_W-1:0];
               r.used = 1'b1;
            end
         end
         OP_WRITE: begin
            // range end at 33 bits so a write near the top never wraps to zero
            lo = {1'b0, sector};
            hi = lo + {{(SECTOR_W + 1 - COUNT_W){1'b0}}, count};
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (tag_valid[drv][s] && {1'b0, tag_sector[drv][s]} >= lo &&
                   {1'b0, tag_sector[drv][s]} < hi)
                  tag_valid[drv][s] = 1'b0;
            end
            r.status = ok ? ST_OK : ST_BACKING_ERR;
         end
         OP_INIT: begin
            for (int s = 0; s < SLOT_COUNT; s++)
               tag_valid[drv][s] = 1'b0;
            fill_ptr[drv] = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // result side first, then request side, so a pop never sees this edge's push
   always @(posedge clock) begin : check_and_predict
      cache_result_type want;
      cache_result_type got;
      if (reset) begin
         clear_tags();
         outstanding.delete();
      end else begin
         if (rsp_strobe) begin
            got = '{hit: rsp_hit, slot: rsp_slot, used: rsp_slot_used, status: rsp_status};
            if (outstanding.size() == 0) begin
               flag_mismatch("result with nothing outstanding", got, 0);
            end else begin
               want = outstanding.pop_front();
               if (got.hit !== want.hit)
                  flag_mismatch("hit", got.hit, want.hit);
               if (got.slot !== want.slot)
                  flag_mismatch("slot", got.slot, want.slot);
               if (got.used !== want.used)
                  flag_mismatch("slot_used", got.used, want.used);
               if (got.status !== want.status)
                  flag_mismatch("status", got.status, want.status);
            end
         end
         if (start && !busy) begin
            // the model always runs so its state follows the block
            want = access_tags(req_op, req_drive, req_sector, req_count, req_backing_ok);
            if (typed_en)
               want = typed_result;
            outstanding.push_back(want);
         end
      end
   end

   // watchdog: a lost result or a stuck busy ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL sector_cache_tag_controller_unit");
         $finish;
      end
   end

   task automatic add_row(input logic [OP_W-1:0] op, input logic drv,
                          input logic [SECTOR_W-1:0] sector, input logic [COUNT_W-1:0] count,
                          input logic ok, input bit pinned, input logic hit,
                          input logic [SLOT_OUT_W-1:0] slot, input logic used,
                          input logic status);
      cache_req_type row;
      row.op = op;
      row.drv = drv;
      row.sector = sector;
      row.count = count;
      row.ok = ok;
      row.pinned = pinned;
      row.want = '{hit: hit, slot: slot, used: used, status: status};
      plan.push_back(row);
   endtask

   // sectors mostly from two small windows (bottom and top of the lba space)
   // so lookups hit often and the fifo pointer wraps; some fully random
   function automatic logic [SECTOR_W-1:0] pick_sector();
      if ($urandom_range(0, 99) < 15)
         return $urandom();
      return ($urandom_range(0, 1) ? 32'hFFFF_FFB0 : 32'h0) + $urandom_range(0, 79);
   endfunction

   function automatic cache_req_type random_request();
      cache_req_type q;
      int pick;
      int c;
      pick = $urandom_range(0, 999);
      c = $urandom_range(0, 99);
      q.drv = 1'($urandom_range(0, 1));
      q.ok = ($urandom_range(0, 99) < 85);
      q.sector = pick_sector();
      q.pinned = PREDICTED;
      q.want = '0;
      if (pick < 650) begin
         q.op = OP_READ;
         if (c < 80)      q.count = 16'd1;
         else if (c < 85) q.count = 16'd0;
         else if (c < 90) q.count = 16'd2;
         else if (c < 95) q.count = COUNT_W'($urandom_range(0, 65535));
         else             q.count = 16'hFFFF;
      end else if (pick < 975) begin
         q.op = OP_WRITE;
         if (c < 55)      q.count = COUNT_W'($urandom_range(0, 4));
         else if (c < 80) q.count = COUNT_W'($urandom_range(0, 40));
         else if (c < 90) q.count = COUNT_W'($urandom_range(0, 65535));
         else if (c < 95) q.count = 16'hFFFF;
         else             q.count = 16'd0;
      end else begin
         // rare drive clears, plus the unused op code
         q.op = (pick < 980) ? OP_INIT : OP_NONE;
         q.count = COUNT_W'($urandom_range(0, 65535));
      end
      return q;
   endfunction

   // present one item and hold it until the edge that takes it
   task automatic send_item(input cache_req_type row, input bit gaps);
      while (gaps && $urandom_range(0, 99) < 28) begin
         start <= 1'b0;
         typed_en <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= row.op;
      req_drive <= row.drv;
      req_sector <= row.sector;
      req_count <= row.count;
      req_backing_ok <= row.ok;
      typed_en <= row.pinned;
      typed_result <= row.want;
      do
         @(posedge clock);
      while (busy);
   endtask

   // at least one edge first, so the item taken at this edge is counted
   task automatic wait_drained();
      do
         @(posedge clock);
      while (outstanding.size() != 0);
   endtask

   initial begin
      // directed part: fills, hits, backing errors, zero and long counts,
      // range invalidation at the top of the lba space, op code 3, clears
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     0, TYPED,     0, 0, 0, ST_BACKING_ERR);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     1, TYPED,     0, 0, 1, ST_OK);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     0, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'hFFFF_FFFF, 16'd1,     1, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_READ,  1, 32'hFFFF_FFFF, 16'd1,     1, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd0,     1, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd0,     0, TYPED,     0, 0, 0, ST_BACKING_ERR);
      add_row(OP_READ,  0, 32'h0000_0000, 16'hFFFF,  1, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'h0000_0005, 16'd2,     0, TYPED,     0, 0, 0, ST_BACKING_ERR);
      add_row(OP_WRITE, 0, 32'hFFFF_FFFF, 16'hFFFF,  1, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'hFFFF_FFFF, 16'd1,     1, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     1, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_WRITE, 0, 32'h0000_0000, 16'd0,     0, TYPED,     0, 0, 0, ST_BACKING_ERR);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     0, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_WRITE, 0, 32'h0000_0000, 16'd1,     0, TYPED,     0, 0, 0, ST_BACKING_ERR);
      add_row(OP_READ,  0, 32'h0000_0000, 16'd1,     0, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_NONE,  1, 32'hFFFF_FFFF, 16'hFFFF,  0, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_INIT,  0, 32'hAAAA_AAAA, 16'h5555,  0, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_READ,  0, 32'hFFFF_FFFF, 16'd1,     1, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_READ,  1, 32'hFFFF_FFFF, 16'd1,     0, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_WRITE, 1, 32'hFFFF_FFF0, 16'h0010,  1, TYPED,     0, 0, 0, ST_OK);
      add_row(OP_READ,  1, 32'hFFFF_FFFF, 16'd1,     0, PREDICTED, 0, 0, 0, ST_OK);
      add_row(OP_INIT,  1, 32'h5555_5555, 16'hAAAA,  1, TYPED,     0, 0, 0, ST_OK);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_item(plan[i], 1'b1);

      // random part: a gap-free stretch over items 400 to 799, and one full drain
      // of outstanding results at the halfway point
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            typed_en <= 1'b0;
            wait_drained();
         end
         send_item(random_request(), !(n >= 400 && n < 800));
      end
      start <= 1'b0;
      typed_en <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS sector_cache_tag_controller_unit");
      else
         $display("FAIL sector_cache_tag_controller_unit");
      $finish;
   end

endmodule
